// ===== src/cpm_pkg.sv =====
// ---------------------------------------------------------------------------
// cpm_pkg: shared types and constants for the cyclic polynomial multiplier
// Coefficient count, modulus width, command and result beat layouts.
// ---------------------------------------------------------------------------
package cpm_pkg;

  localparam int NUM_COEFFS  = 701;
  localparam int LOG_MODULUS = 13;
  localparam int ADDR_W      = $clog2(NUM_COEFFS);

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic        [9:0]  index;
    logic signed [15:0] a_coeff;
    logic signed [15:0] b_coeff;
  } cmd_t;

  typedef struct packed {
    logic [9:0]             result_index;
    logic [LOG_MODULUS-1:0] product_coeff;
  } rsp_t;

  // Control that travels with each operand pair into the MAC pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

// ===== src/cpm_mac.sv =====
// ---------------------------------------------------------------------------
// cpm_mac: multiply-accumulate pipeline mod 2^LOG_MODULUS
// One registered multiply, one registered accumulate; pulses done on the
// last term of a sum.
// ---------------------------------------------------------------------------
module cpm_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  cpm_pkg::mac_ctrl_t             ctrl,
  input  logic [cpm_pkg::LOG_MODULUS-1:0] a_val,
  input  logic [cpm_pkg::LOG_MODULUS-1:0] b_val,
  output logic                           done,
  output logic [cpm_pkg::LOG_MODULUS-1:0] acc
);
  import cpm_pkg::*;

  logic [2*LOG_MODULUS-1:0] prod_full;
  logic [LOG_MODULUS-1:0]   prod;
  mac_ctrl_t                prod_ctrl;

  assign prod_full = a_val * b_val;

  always_ff @(posedge clk) begin
    prod <= prod_full[LOG_MODULUS-1:0];
    if (rst) begin
      prod_ctrl <= '0;
    end else begin
      prod_ctrl <= ctrl;
    end
  end

  // The sum wraps naturally mod 2^LOG_MODULUS.
  always_ff @(posedge clk) begin
    if (prod_ctrl.valid) begin
      acc <= prod_ctrl.first ? prod : acc + prod;
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_ctrl.valid & prod_ctrl.last;
    end
  end

endmodule

// ===== src/cyclic_poly_mul_mod_q_top.sv =====
// ---------------------------------------------------------------------------
// cyclic_poly_mul_mod_q_top: product of two polynomials mod x^N - 1 and mod Q
// A store beat leaves busy low. A read beat with an index inside the range
// walks both operand memories, one product term per cycle, then drains the
// registered read, multiply and accumulate stages; busy stays high until
// the result strobe. An out-of-range read answers the next cycle.
// Reset clears control only; operand memories hold garbage until written.
// The receiver cannot stall: strobe is high for exactly one cycle per result.
// ---------------------------------------------------------------------------
module cyclic_poly_mul_mod_q_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cpm_pkg::cmd_t cmd,
  output logic          busy,
  output logic          strobe,
  output cpm_pkg::rsp_t result
);
  import cpm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_COEFFS - 1);

  logic [LOG_MODULUS-1:0] a_mem [NUM_COEFFS];
  logic [LOG_MODULUS-1:0] b_mem [NUM_COEFFS];

  state_t                 state;
  logic [ADDR_W-1:0]      a_addr;
  logic [ADDR_W-1:0]      b_addr;
  logic [9:0]             read_index;
  logic [LOG_MODULUS-1:0] a_q;
  logic [LOG_MODULUS-1:0] b_q;
  mac_ctrl_t              rd_ctrl;
  mac_ctrl_t              mac_ctrl;
  logic                   mac_done;
  logic [LOG_MODULUS-1:0] mac_acc;

  logic accept;
  logic in_range;
  logic store_en;

  assign accept   = start & ~busy;
  assign in_range = 32'(cmd.index) < NUM_COEFFS;
  assign store_en = accept & (cmd.opcode == OP_STORE) & in_range;
  assign busy     = (state != S_IDLE);

  // Operand memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (store_en) begin
      a_mem[ADDR_W'(cmd.index)] <= cmd.a_coeff[LOG_MODULUS-1:0];
      b_mem[ADDR_W'(cmd.index)] <= cmd.b_coeff[LOG_MODULUS-1:0];
    end
    a_q <= a_mem[a_addr];
    b_q <= b_mem[b_addr];
  end

  always_comb begin
    rd_ctrl.valid = (state == S_RUN);
    rd_ctrl.first = (a_addr == '0);
    rd_ctrl.last  = (a_addr == LAST_ADDR);
  end

  // Control is registered to line up with the registered memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_ctrl <= '0;
    end else begin
      mac_ctrl <= rd_ctrl;
    end
  end

  cpm_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (mac_ctrl),
    .a_val (a_q),
    .b_val (b_q),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && cmd.opcode == OP_READ) begin
            read_index <= cmd.index;
            if (in_range) begin
              a_addr <= '0;
              b_addr <= ADDR_W'(cmd.index);
              state  <= S_RUN;
            end else begin
              strobe                <= 1'b1;
              result.result_index  <= cmd.index;
              result.product_coeff <= '0;
            end
          end
        end
        S_RUN: begin
          // Advance a forward, b backward with wrap to the top entry.
          a_addr <= a_addr + 1'b1;
          b_addr <= (b_addr == '0) ? LAST_ADDR : b_addr - 1'b1;
          if (a_addr == LAST_ADDR) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (mac_done) begin
            strobe                <= 1'b1;
            result.result_index  <= read_index;
            result.product_coeff <= mac_acc;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for cyclic_poly_mul_mod_q_top
// Sends out-of-range traffic, loads both operand polynomials, then mixes
// stores and reads of product coefficients (inside and outside the index
// range) with random gaps. Each read is predicted from a local copy of the
// operand memories and compared field by field with the strobed result.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cpm_pkg::*;

  localparam int unsigned MOD_MASK   = (1 << LOG_MODULUS) - 1;
  localparam int          RAND_BEATS = 130;
  localparam int          MAX_INDEX  = 1023;

  logic  clk   = 1'b0;
  logic  rst   = 1'b1;
  logic  start = 1'b0;
  cmd_t  cmd   = '0;
  logic  busy;
  logic  strobe;
  rsp_t  result;

  cyclic_poly_mul_mod_q_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local copy of the operand memories, kept as residues mod Q.
  logic [LOG_MODULUS-1:0] coef_a [NUM_COEFFS];
  logic [LOG_MODULUS-1:0] coef_b [NUM_COEFFS];

  cmd_t pending_q [$];
  rsp_t product_q [$];

  int n_store     = 0;
  int n_ignored   = 0;
  int n_read_in   = 0;
  int n_read_out  = 0;
  int n_checked   = 0;
  int mismatches  = 0;

  function automatic logic [LOG_MODULUS-1:0] product_coeff_at(int unsigned k);
    int unsigned acc;
    int unsigned j;
    acc = 0;
    for (int unsigned i = 0; i < NUM_COEFFS; i++) begin
      j   = (k >= i) ? k - i : k + NUM_COEFFS - i;
      acc = (acc + coef_a[i] * coef_b[j]) & MOD_MASK;
    end
    return acc[LOG_MODULUS-1:0];
  endfunction

  function automatic void predict_beat(cmd_t c);
    rsp_t r;
    if (c.opcode == OP_STORE) begin
      if (c.index < NUM_COEFFS) begin
        coef_a[c.index] = c.a_coeff[LOG_MODULUS-1:0];
        coef_b[c.index] = c.b_coeff[LOG_MODULUS-1:0];
        n_store++;
      end else begin
        n_ignored++;
      end
    end else begin
      r.result_index = c.index;
      if (c.index < NUM_COEFFS) begin
        r.product_coeff = product_coeff_at(32'(c.index));
        n_read_in++;
      end else begin
        r.product_coeff = '0;
        n_read_out++;
      end
      product_q.push_back(r);
    end
  endfunction

  function automatic logic signed [15:0] pick_coeff();
    case ($urandom_range(0, 15))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd8191;
      5:       return 16'sd8192;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic void push_cmd(opcode_t op, logic [9:0] idx,
                                   logic signed [15:0] a, logic signed [15:0] b);
    cmd_t c;
    c.opcode  = op;
    c.index   = idx;
    c.a_coeff = a;
    c.b_coeff = b;
    pending_q.push_back(c);
  endfunction

  // Driver: one beat per accepted start, random gap between beats,
  // with occasional back-to-back stretches.
  logic nxt_start;
  cmd_t nxt_cmd;
  int   gap_left   = 0;
  int   burst_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd   <= '0;
    end else begin
      nxt_start = start;
      nxt_cmd   = cmd;
      if (start && !busy) begin
        predict_beat(cmd);
        nxt_start = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 29) == 0) begin
          burst_left = $urandom_range(10, 40);
          gap_left   = 0;
        end else begin
          gap_left = $urandom_range(0, 6);
        end
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          nxt_cmd   = pending_q.pop_front();
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
      cmd   <= nxt_cmd;
    end
  end

  // Monitor: every strobe must match the oldest predicted coefficient.
  rsp_t want;

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (product_q.size() == 0) begin
        $display("%0t: unexpected result index %0d coeff %0d", $realtime,
                 result.result_index, result.product_coeff);
        mismatches++;
      end else begin
        want = product_q.pop_front();
        n_checked++;
        if (result.result_index !== want.result_index) begin
          $display("%0t: result_index expected %0d actual %0d", $realtime,
                   want.result_index, result.result_index);
          mismatches++;
        end
        if (result.product_coeff !== want.product_coeff) begin
          $display("%0t: product_coeff at %0d expected %0d actual %0d", $realtime,
                   want.result_index, want.product_coeff, result.product_coeff);
          mismatches++;
        end
      end
    end
  end

  int useful;
  int sel;

  initial begin
    // Out-of-range traffic is legal before any operand is written.
    push_cmd(OP_READ, 10'(NUM_COEFFS), pick_coeff(), pick_coeff());
    push_cmd(OP_READ, 10'(MAX_INDEX), -16'sd1, -16'sd1);
    push_cmd(OP_STORE, 10'(MAX_INDEX), -16'sd1, -16'sd1);
    push_cmd(OP_STORE, 10'(NUM_COEFFS), 16'sd5, 16'sd7);

    // Fill every entry before the first in-range read.
    push_cmd(OP_STORE, 10'd0, -16'sd32768, 16'sd32767);
    for (int i = 1; i < NUM_COEFFS - 1; i++)
      push_cmd(OP_STORE, 10'(i), pick_coeff(), pick_coeff());
    push_cmd(OP_STORE, 10'(NUM_COEFFS - 1), 16'sd32767, -16'sd32768);

    push_cmd(OP_READ, 10'd0, 16'sd0, 16'sd0);
    push_cmd(OP_READ, 10'(NUM_COEFFS - 1), -16'sd1, -16'sd1);
    push_cmd(OP_READ, 10'(NUM_COEFFS / 2), pick_coeff(), pick_coeff());
    // Store past the end must leave the operands untouched.
    push_cmd(OP_STORE, 10'(MAX_INDEX), 16'sd1234, -16'sd4321);
    push_cmd(OP_READ, 10'(NUM_COEFFS - 1), 16'sd0, 16'sd0);
    push_cmd(OP_STORE, 10'd0, -16'sd1, -16'sd1);
    push_cmd(OP_READ, 10'd0, 16'sd0, 16'sd0);
    push_cmd(OP_READ, 10'd1, 16'sd0, 16'sd0);
    push_cmd(OP_STORE, 10'(NUM_COEFFS - 1), 16'sd0, 16'sd0);
    push_cmd(OP_READ, 10'(NUM_COEFFS - 2), 16'sd0, 16'sd0);
    push_cmd(OP_STORE, 10'd1, 16'sd8192, 16'sd8191);
    push_cmd(OP_READ, 10'd1, 16'sd0, 16'sd0);
    push_cmd(OP_READ, 10'd1000, pick_coeff(), pick_coeff());

    useful = 0;
    while (useful < RAND_BEATS) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        push_cmd(OP_STORE, 10'($urandom_range(0, NUM_COEFFS - 1)),
                 pick_coeff(), pick_coeff());
        useful++;
      end else if (sel < 66) begin
        push_cmd(OP_STORE, 10'($urandom_range(NUM_COEFFS, MAX_INDEX)),
                 pick_coeff(), pick_coeff());
      end else if (sel < 92) begin
        push_cmd(OP_READ, 10'($urandom_range(0, NUM_COEFFS - 1)),
                 pick_coeff(), pick_coeff());
        useful++;
      end else begin
        push_cmd(OP_READ, 10'($urandom_range(NUM_COEFFS, MAX_INDEX)),
                 pick_coeff(), pick_coeff());
        useful++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || start || product_q.size() != 0)
      @(posedge clk);
    // Drain: allow one full read walk for any stray strobe.
    repeat (NUM_COEFFS + 10) @(posedge clk);

    $display("tb_top: %0d stores, %0d ignored stores, %0d in-range reads, %0d out-of-range reads",
             n_store, n_ignored, n_read_in, n_read_out);
    $display("tb_top: %0d results checked, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #60ms;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
